### src/agrc_pkg.sv
// Shared constants and types for the access grant range checker.
`timescale 1ns / 1ps
package agrc_pkg;

  localparam int PORT_ENTRIES   = 8;
  localparam int MEM_ENTRIES    = 8;
  localparam int VECTOR_ENTRIES = 8;
  localparam int ADDR_WIDTH     = 32;

  localparam int FIELD_W = 32;
  localparam int AW      = (ADDR_WIDTH < FIELD_W) ? ADDR_WIDTH : FIELD_W;
  localparam int VEC_W   = 8;

  localparam int PORT_CW = $clog2(PORT_ENTRIES + 1);
  localparam int MEM_CW  = $clog2(MEM_ENTRIES + 1);
  localparam int VEC_CW  = $clog2(VECTOR_ENTRIES + 1);

  localparam logic [2:0] MODE_ADD_PORT = 3'd0;
  localparam logic [2:0] MODE_ADD_MEM  = 3'd1;
  localparam logic [2:0] MODE_ADD_VEC  = 3'd2;
  localparam logic [2:0] MODE_CHK_PORT = 3'd3;
  localparam logic [2:0] MODE_CHK_MEM  = 3'd4;
  localparam logic [2:0] MODE_CHK_VEC  = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DENY = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic tok;
    logic hit;
  } link_t;

endpackage

### src/agrc_range_cell.sv
// One range entry of a grant chain: holds start and length, tests the passing query.
`timescale 1ns / 1ps
module agrc_range_cell
  import agrc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_start,
  input  logic [AW-1:0] wr_len,
  input  logic          live,
  input  logic [AW-1:0] q_addr,
  input  logic [AW-1:0] q_size,
  input  link_t         link_in,
  output link_t         link_out
);

  logic [AW-1:0] start;
  logic [AW-1:0] len;
  logic [AW:0]   acc_end;
  logic [AW:0]   rng_end;
  logic          match;

  assign acc_end = {1'b0, q_addr} + {1'b0, q_size};
  assign rng_end = {1'b0, start} + {1'b0, len};
  assign match   = live && (q_addr >= start) && (acc_end <= rng_end);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      start <= wr_start;
      len   <= wr_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_out.tok <= 1'b0;
    end else begin
      link_out.tok <= link_in.tok;
    end
    link_out.hit <= link_in.hit || (link_in.tok && match);
  end

endmodule

### src/agrc_vector_cell.sv
// One interrupt vector entry of a grant chain: holds a vector, tests the passing query.
`timescale 1ns / 1ps
module agrc_vector_cell
  import agrc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [VEC_W-1:0] wr_vec,
  input  logic             live,
  input  logic [VEC_W-1:0] q_vec,
  input  link_t            link_in,
  output link_t            link_out
);

  logic [VEC_W-1:0] vec;
  logic             match;

  assign match = live && (vec == q_vec);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      vec <= wr_vec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_out.tok <= 1'b0;
    end else begin
      link_out.tok <= link_in.tok;
    end
    link_out.hit <= link_in.hit || (link_in.tok && match);
  end

endmodule

### src/access_grant_range_checker.sv
// Top level: three grant chains (port, memory, vector) with append and check control.
//
//   channel | handshake               | payload
//   --------+-------------------------+----------------------------------------------
//   in      | in_valid / in_stall     | mode, address, range_length, access_size, vector
//   out     | out_valid / out_stall   | status
//
// An add or an unused mode has its status registered the cycle after accept.
// A check walks a token down the chosen chain, one entry per cycle; no new transaction
// is taken until that walk has ended.
// Synchronous reset empties all three tables (counts to zero) and drops any walk.
// A held result stalls input only while it is still waiting at the output.
`timescale 1ns / 1ps
module access_grant_range_checker
  import agrc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         mode,
  input  logic [FIELD_W-1:0] address,
  input  logic [FIELD_W-1:0] range_length,
  input  logic [FIELD_W-1:0] access_size,
  input  logic [VEC_W-1:0]   vector,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status
);

  logic [PORT_CW-1:0] port_count;
  logic [MEM_CW-1:0]  mem_count;
  logic [VEC_CW-1:0]  vector_count;

  logic               busy;
  logic               launch_port;
  logic               launch_mem;
  logic               launch_vec;

  logic [AW-1:0]      q_addr;
  logic [AW-1:0]      q_size;
  logic [VEC_W-1:0]   q_vec;

  logic               acc;
  logic               port_full;
  logic               mem_full;
  logic               vec_full;
  logic               walk_end;
  logic               walk_hit;

  link_t port_link [PORT_ENTRIES + 1];
  link_t mem_link  [MEM_ENTRIES + 1];
  link_t vec_link  [VECTOR_ENTRIES + 1];

  assign in_stall  = busy || (out_valid && out_stall);
  assign acc       = in_valid && !in_stall;
  assign port_full = (port_count == PORT_CW'(PORT_ENTRIES));
  assign mem_full  = (mem_count == MEM_CW'(MEM_ENTRIES));
  assign vec_full  = (vector_count == VEC_CW'(VECTOR_ENTRIES));

  assign port_link[0] = '{tok: launch_port, hit: 1'b0};
  assign mem_link[0]  = '{tok: launch_mem, hit: 1'b0};
  assign vec_link[0]  = '{tok: launch_vec, hit: 1'b0};

  assign walk_end = port_link[PORT_ENTRIES].tok || mem_link[MEM_ENTRIES].tok ||
                    vec_link[VECTOR_ENTRIES].tok;
  assign walk_hit = (port_link[PORT_ENTRIES].tok && port_link[PORT_ENTRIES].hit) ||
                    (mem_link[MEM_ENTRIES].tok && mem_link[MEM_ENTRIES].hit) ||
                    (vec_link[VECTOR_ENTRIES].tok && vec_link[VECTOR_ENTRIES].hit);

  for (genvar i = 0; i < PORT_ENTRIES; i++) begin : g_port
    agrc_range_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .wr_en    (acc && (mode == MODE_ADD_PORT) && (port_count == PORT_CW'(i))),
      .wr_start (address[AW-1:0]),
      .wr_len   (range_length[AW-1:0]),
      .live     (port_count > PORT_CW'(i)),
      .q_addr   (q_addr),
      .q_size   (q_size),
      .link_in  (port_link[i]),
      .link_out (port_link[i+1])
    );
  end

  for (genvar i = 0; i < MEM_ENTRIES; i++) begin : g_mem
    agrc_range_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .wr_en    (acc && (mode == MODE_ADD_MEM) && (mem_count == MEM_CW'(i))),
      .wr_start (address[AW-1:0]),
      .wr_len   (range_length[AW-1:0]),
      .live     (mem_count > MEM_CW'(i)),
      .q_addr   (q_addr),
      .q_size   (q_size),
      .link_in  (mem_link[i]),
      .link_out (mem_link[i+1])
    );
  end

  for (genvar i = 0; i < VECTOR_ENTRIES; i++) begin : g_vec
    agrc_vector_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .wr_en    (acc && (mode == MODE_ADD_VEC) && (vector_count == VEC_CW'(i))),
      .wr_vec   (vector),
      .live     (vector_count > VEC_CW'(i)),
      .q_vec    (q_vec),
      .link_in  (vec_link[i]),
      .link_out (vec_link[i+1])
    );
  end

  // query operands stay put for the whole walk
  always_ff @(posedge clk) begin
    if (acc) begin
      q_addr <= address[AW-1:0];
      q_size <= access_size[AW-1:0];
      q_vec  <= vector;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      port_count   <= '0;
      mem_count    <= '0;
      vector_count <= '0;
      busy         <= 1'b0;
      launch_port  <= 1'b0;
      launch_mem   <= 1'b0;
      launch_vec   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      launch_port <= 1'b0;
      launch_mem  <= 1'b0;
      launch_vec  <= 1'b0;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (walk_end) begin
        busy      <= 1'b0;
        out_valid <= 1'b1;
        status    <= walk_hit ? ST_OK : ST_DENY;
      end
      if (acc) begin
        case (mode)
          MODE_ADD_PORT: begin
            out_valid <= 1'b1;
            status    <= port_full ? ST_FULL : ST_OK;
            if (!port_full) begin
              port_count <= port_count + PORT_CW'(1);
            end
          end
          MODE_ADD_MEM: begin
            out_valid <= 1'b1;
            status    <= mem_full ? ST_FULL : ST_OK;
            if (!mem_full) begin
              mem_count <= mem_count + MEM_CW'(1);
            end
          end
          MODE_ADD_VEC: begin
            out_valid <= 1'b1;
            status    <= vec_full ? ST_FULL : ST_OK;
            if (!vec_full) begin
              vector_count <= vector_count + VEC_CW'(1);
            end
          end
          MODE_CHK_PORT: begin
            busy        <= 1'b1;
            launch_port <= 1'b1;
          end
          MODE_CHK_MEM: begin
            busy       <= 1'b1;
            launch_mem <= 1'b1;
          end
          MODE_CHK_VEC: begin
            busy       <= 1'b1;
            launch_vec <= 1'b1;
          end
          default: begin
            out_valid <= 1'b1;
            status    <= ST_DENY;
          end
        endcase
      end
    end
  end

endmodule

### src/agrc_checker.sv
// Port-level assertions for the access grant range checker, bound to the top level.
`timescale 1ns / 1ps
module agrc_checker
  import agrc_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic [2:0]         mode,
  input logic [FIELD_W-1:0] address,
  input logic [FIELD_W-1:0] range_length,
  input logic [FIELD_W-1:0] access_size,
  input logic [VEC_W-1:0]   vector,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         status
);

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

  a_add_status: assert property (@(posedge clk) disable iff (rst)
    in_acc && (mode == MODE_ADD_PORT || mode == MODE_ADD_MEM || mode == MODE_ADD_VEC)
    |=> out_valid && (status == ST_OK || status == ST_FULL))
    else $error("add transaction without ok or full status");

  a_unused_deny: assert property (@(posedge clk) disable iff (rst)
    in_acc && mode != MODE_ADD_PORT && mode != MODE_ADD_MEM && mode != MODE_ADD_VEC &&
    mode != MODE_CHK_PORT && mode != MODE_CHK_MEM && mode != MODE_CHK_VEC
    |=> out_valid && status == ST_DENY)
    else $error("unused mode not denied");

  a_check_latency: assert property (@(posedge clk) disable iff (rst)
    in_acc && (mode == MODE_CHK_PORT || mode == MODE_CHK_MEM || mode == MODE_CHK_VEC)
    |=> in_stall && !out_valid)
    else $error("check transaction did not hold the input");

endmodule

bind access_grant_range_checker agrc_checker u_agrc_checker (.*);

### tb/sv/access_grant_scoreboard.sv
// Watches both channels of the grant range checker, predicts each status and compares.
`timescale 1ns / 1ps
module access_grant_scoreboard
  import agrc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [2:0]         mode,
  input  logic [FIELD_W-1:0] address,
  input  logic [FIELD_W-1:0] range_length,
  input  logic [FIELD_W-1:0] access_size,
  input  logic [VEC_W-1:0]   vector,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [1:0]         status,
  output int                 mismatches,
  output int                 pending,
  output int                 compared
);

  typedef struct {
    logic [1:0]         status;
    logic [2:0]         mode;
    logic [FIELD_W-1:0] address;
    int                 seq;
  } grant_expect_t;

  logic [AW-1:0]    port_start [PORT_ENTRIES];
  logic [AW-1:0]    port_len   [PORT_ENTRIES];
  logic [AW-1:0]    mem_start  [MEM_ENTRIES];
  logic [AW-1:0]    mem_len    [MEM_ENTRIES];
  logic [VEC_W-1:0] vec_list   [VECTOR_ENTRIES];
  int               port_n;
  int               mem_n;
  int               vec_n;
  int               accepted;

  grant_expect_t expected_status[$];
  grant_expect_t want;

  initial begin
    mismatches = 0;
    pending    = 0;
    compared   = 0;
    accepted   = 0;
    port_n     = 0;
    mem_n      = 0;
    vec_n      = 0;
  end

  // exact containment: start <= a and a + sz <= start + len, no wrap
  function automatic bit range_covers(logic [AW-1:0] lo, logic [AW-1:0] len,
                                      logic [AW-1:0] a, logic [AW-1:0] sz);
    bit [AW:0] hit_end;
    bit [AW:0] rng_end;
    hit_end = {1'b0, a} + {1'b0, sz};
    rng_end = {1'b0, lo} + {1'b0, len};
    return (a >= lo) && (hit_end <= rng_end);
  endfunction

  function automatic logic [1:0] grant_decision(logic [2:0] m, logic [AW-1:0] a,
                                                logic [AW-1:0] len, logic [AW-1:0] sz,
                                                logic [VEC_W-1:0] v);
    logic [1:0] st;
    st = ST_DENY;
    case (m)
      MODE_ADD_PORT: begin
        if (port_n < PORT_ENTRIES) begin
          port_start[port_n] = a;
          port_len[port_n]   = len;
          port_n++;
          st = ST_OK;
        end else st = ST_FULL;
      end
      MODE_ADD_MEM: begin
        if (mem_n < MEM_ENTRIES) begin
          mem_start[mem_n] = a;
          mem_len[mem_n]   = len;
          mem_n++;
          st = ST_OK;
        end else st = ST_FULL;
      end
      MODE_ADD_VEC: begin
        if (vec_n < VECTOR_ENTRIES) begin
          vec_list[vec_n] = v;
          vec_n++;
          st = ST_OK;
        end else st = ST_FULL;
      end
      MODE_CHK_PORT: begin
        for (int i = 0; i < port_n; i++)
          if (range_covers(port_start[i], port_len[i], a, sz)) st = ST_OK;
      end
      MODE_CHK_MEM: begin
        for (int i = 0; i < mem_n; i++)
          if (range_covers(mem_start[i], mem_len[i], a, sz)) st = ST_OK;
      end
      MODE_CHK_VEC: begin
        for (int i = 0; i < vec_n; i++)
          if (vec_list[i] == v) st = ST_OK;
      end
      default: st = ST_DENY;
    endcase
    return st;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      port_n = 0;
      mem_n  = 0;
      vec_n  = 0;
      expected_status.delete();
    end else begin
      if (in_valid && !in_stall) begin
        want.mode    = mode;
        want.address = address;
        want.seq     = accepted;
        want.status  = grant_decision(mode, address[AW-1:0], range_length[AW-1:0],
                                      access_size[AW-1:0], vector);
        expected_status = {expected_status, want};
        accepted++;
      end
      if (out_valid && !out_stall) begin
        if (expected_status.size() == 0) begin
          report_mismatch($sformatf("status %0d with no transaction outstanding", status));
        end else begin
          want = expected_status.pop_front();
          compared++;
          if (status !== want.status)
            report_mismatch($sformatf("transaction %0d mode %0d addr %h: status %0d, want %0d",
                                      want.seq, want.mode, want.address, status,
                                      want.status));
        end
      end
    end
    pending = expected_status.size();
  end

endmodule

### tb/sv/access_grant_range_checker_tb.sv
// Testbench top: drives grant adds and access checks into the range checker, gives the verdict.
`timescale 1ns / 1ps
module access_grant_range_checker_tb;
  import agrc_pkg::*;

  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;
  localparam int         RANDOM_ITEMS  = 1700;
  localparam int         CYCLE_LIMIT   = 600000;
  localparam int         DRAIN_CYCLES  = PORT_ENTRIES + MEM_ENTRIES + 8;

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               in_valid     = 1'b0;
  logic               in_stall;
  logic [2:0]         mode         = MODE_CHK_VEC;
  logic [FIELD_W-1:0] address      = '0;
  logic [FIELD_W-1:0] range_length = '0;
  logic [FIELD_W-1:0] access_size  = '0;
  logic [VEC_W-1:0]   vector       = '0;
  logic               out_valid;
  logic               out_stall    = 1'b0;
  logic [1:0]         status;

  int mismatches;
  int pending;
  int compared;
  int cycle_count = 0;
  int n_add       = 0;
  int n_check     = 0;
  int n_spare     = 0;
  bit calm        = 1'b0;

  logic [31:0] port_lo[$];
  logic [31:0] port_span[$];
  logic [31:0] mem_lo[$];
  logic [31:0] mem_span[$];
  logic [7:0]  vec_seen[$];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  access_grant_range_checker u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .address      (address),
    .range_length (range_length),
    .access_size  (access_size),
    .vector       (vector),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status)
  );

  access_grant_scoreboard u_scoreboard (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .address      (address),
    .range_length (range_length),
    .access_size  (access_size),
    .vector       (vector),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .mismatches   (mismatches),
    .pending      (pending),
    .compared     (compared)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // result side back-pressure
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(0, 5)) @(posedge clk);
    end
  end

  // called just after a rising edge; returns at the edge that accepts the transaction
  task automatic send(input logic [2:0] m, input logic [31:0] a, input logic [31:0] len,
                      input logic [31:0] sz, input logic [7:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    mode         <= m;
    address      <= a;
    range_length <= len;
    access_size  <= sz;
    vector       <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    case (m)
      MODE_ADD_PORT, MODE_ADD_MEM, MODE_ADD_VEC: n_add++;
      MODE_CHK_PORT, MODE_CHK_MEM, MODE_CHK_VEC: n_check++;
      default: n_spare++;
    endcase
  endtask

  // access aimed at the edges of or inside a stored range
  task automatic aim_at(input logic [31:0] lo, input logic [31:0] len,
                        output logic [31:0] a, output logic [31:0] sz);
    logic [31:0] span1;
    span1 = len + 32'd1;
    case ($urandom_range(0, 3))
      0: a = lo - $urandom_range(0, 2);
      1: a = lo + len - $urandom_range(0, 2);
      2: a = lo + ((span1 == 0) ? $urandom : ($urandom % span1));
      default: a = lo;
    endcase
    case ($urandom_range(0, 3))
      0: sz = $urandom_range(0, 8);
      1: sz = lo + len - a + $urandom_range(0, 1) - 32'd0;
      2: sz = 32'd1 << $urandom_range(0, 2);
      default: sz = $urandom;
    endcase
    if ($urandom_range(0, 3) == 0 && sz != 0) sz = sz - 32'd1;
  endtask

  initial begin
    int          r;
    int          idx;
    logic [31:0] a;
    logic [31:0] len;
    logic [31:0] sz;
    logic [7:0]  v;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty tables, spare modes
    send(MODE_CHK_PORT, 32'h0, 32'h0, 32'h1, 8'h00);
    send(MODE_CHK_MEM, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    send(MODE_CHK_VEC, 32'h0, 32'h0, 32'h0, 8'h00);
    send(MODE_SPARE_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    send(MODE_SPARE_HI, 32'h0, 32'h0, 32'h0, 8'h00);
    // exact fit, one past, below start, zero size at the far end
    send(MODE_ADD_PORT, 32'h1000, 32'h100, 32'h0, 8'h00);
    send(MODE_CHK_PORT, 32'h1000, 32'h0, 32'h100, 8'h00);
    send(MODE_CHK_PORT, 32'h1001, 32'h0, 32'h100, 8'h00);
    send(MODE_CHK_PORT, 32'h0FFF, 32'h0, 32'h1, 8'h00);
    send(MODE_CHK_PORT, 32'h1100, 32'h0, 32'h0, 8'h00);
    // zero-length range
    send(MODE_ADD_PORT, 32'h2000, 32'h0, 32'h0, 8'h00);
    send(MODE_CHK_PORT, 32'h2000, 32'h0, 32'h0, 8'h00);
    send(MODE_CHK_PORT, 32'h2000, 32'h0, 32'h1, 8'h00);
    // ranges reaching to or past the top of the address space
    send(MODE_ADD_MEM, 32'h8000_0000, 32'h8000_0000, 32'h0, 8'h00);
    send(MODE_CHK_MEM, 32'hFFFF_FFFC, 32'h0, 32'h4, 8'h00);
    send(MODE_CHK_MEM, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 8'h00);
    send(MODE_ADD_MEM, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 8'h00);
    send(MODE_CHK_MEM, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 8'h00);
    // vectors and a duplicate port grant
    send(MODE_ADD_VEC, 32'h0, 32'h0, 32'h0, 8'hFF);
    send(MODE_ADD_VEC, 32'h0, 32'h0, 32'h0, 8'h00);
    send(MODE_ADD_PORT, 32'h1000, 32'h100, 32'h0, 8'h00);
    send(MODE_CHK_VEC, 32'h0, 32'h0, 32'h0, 8'hFF);
    send(MODE_CHK_VEC, 32'h0, 32'h0, 32'h0, 8'h80);

    port_lo   = {port_lo, 32'h1000};
    port_span = {port_span, 32'h100};
    port_lo   = {port_lo, 32'h2000};
    port_span = {port_span, 32'h0};
    mem_lo    = {mem_lo, 32'h8000_0000};
    mem_span  = {mem_span, 32'h8000_0000};
    vec_seen  = {vec_seen, 8'hFF};
    vec_seen  = {vec_seen, 8'h00};

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i % 400) >= 340;
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send(r[0] ? MODE_SPARE_HI : MODE_SPARE_LO, $urandom, $urandom, $urandom,
             8'($urandom));
      end else if (r < 9) begin
        case ($urandom_range(0, 2))
          0: a = $urandom;
          1: a = 32'hFFFF_FFFF - $urandom_range(0, 300);
          default: a = $urandom_range(0, 300);
        endcase
        case ($urandom_range(0, 3))
          0: len = 32'h0;
          1: len = $urandom_range(1, 64);
          2: len = $urandom_range(1, 65536);
          default: len = $urandom;
        endcase
        v = 8'($urandom);
        case ($urandom_range(0, 2))
          0: begin
            port_lo   = {port_lo, a};
            port_span = {port_span, len};
            send(MODE_ADD_PORT, a, len, $urandom, v);
          end
          1: begin
            mem_lo   = {mem_lo, a};
            mem_span = {mem_span, len};
            send(MODE_ADD_MEM, a, len, $urandom, v);
          end
          default: begin
            vec_seen = {vec_seen, v};
            send(MODE_ADD_VEC, a, len, $urandom, v);
          end
        endcase
      end else if (r < 40) begin
        if ($urandom_range(0, 4) != 0) begin
          idx = $urandom_range(0, port_lo.size() - 1);
          aim_at(port_lo[idx], port_span[idx], a, sz);
        end else begin
          a  = $urandom;
          sz = $urandom;
        end
        send(MODE_CHK_PORT, a, $urandom, sz, 8'($urandom));
      end else if (r < 75) begin
        if ($urandom_range(0, 4) != 0) begin
          idx = $urandom_range(0, mem_lo.size() - 1);
          aim_at(mem_lo[idx], mem_span[idx], a, sz);
        end else begin
          a  = $urandom;
          sz = $urandom;
        end
        send(MODE_CHK_MEM, a, $urandom, sz, 8'($urandom));
      end else begin
        if ($urandom_range(0, 9) < 7)
          v = vec_seen[$urandom_range(0, vec_seen.size() - 1)];
        else
          v = 8'($urandom);
        send(MODE_CHK_VEC, $urandom, $urandom, $urandom, v);
      end
    end

    in_valid <= 1'b0;
    calm = 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d transactions: %0d grant adds, %0d access checks, %0d spare-mode",
             n_add + n_check + n_spare, n_add, n_check, n_spare);
    $display("compared %0d statuses, %0d mismatches, %0d cycles",
             compared, mismatches, cycle_count);
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

### sim.f
src/agrc_pkg.sv
src/agrc_range_cell.sv
src/agrc_vector_cell.sv
src/access_grant_range_checker.sv
src/agrc_checker.sv
tb/sv/access_grant_scoreboard.sv
tb/sv/access_grant_range_checker_tb.sv
